// ===== design/dtts_pkg.sv =====
// ----------------------------------------------------------------------------
// dtts_pkg
// Shared types, constants and keyword tables for the duration text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtts_pkg;

    // Default signed field width of one digit group
    localparam int DTTS_FIELD_BITS = 32;

    // Result widths
    localparam int SEC_W = 31;
    localparam int MIN_W = 26;

    localparam logic [SEC_W-1:0] MAX_TOTAL = 31'h7FFF_FFFF;

    // Scale factors to seconds
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int ROUND_UP_MIN  = 59;

    // floor(n / 15) == (n * RECIP_15) >> RECIP_SHIFT for any n below 2^32
    localparam logic [31:0] RECIP_15    = 32'h8888_8889;
    localparam int          RECIP_SHIFT = 35;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Keywords meaning an unlimited duration
    localparam int          KW_COUNT     = 3;
    localparam logic [1:0]  KW_DASH_ONE  = 2'd0;
    localparam logic [1:0]  KW_INFINITE  = 2'd1;
    localparam logic [1:0]  KW_UNLIMITED = 2'd2;
    localparam int          KW_MAX_LEN   = 9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INFINITE = 2'd1,
        ST_INVALID  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // One character of text
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } dtts_in_t;

    // One result word
    typedef struct packed {
        status_t            status;
        logic [SEC_W-1:0]   total_seconds;
        logic [MIN_W-1:0]   total_minutes;
    } dtts_out_t;

    // Parsed text handed to the arithmetic; status is final unless ST_OK
    typedef struct packed {
        status_t            status;
        logic [SEC_W-1:0]   days;
        logic [SEC_W-1:0]   hours;
        logic [SEC_W-1:0]   mins;
        logic [SEC_W-1:0]   secs;
    } dtts_snap_t;

    // Seconds total with final status
    typedef struct packed {
        status_t            status;
        logic [SEC_W-1:0]   seconds;
    } dtts_secs_t;

    // Length of a keyword
    function automatic logic [3:0] kw_len(input logic [1:0] kw);
        logic [3:0] len;
        unique case (kw)
            KW_DASH_ONE:  len = 4'd2;
            KW_INFINITE:  len = 4'd8;
            KW_UNLIMITED: len = 4'd9;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    // Upper-case character of a keyword at a position; zero past the end
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [3:0] idx);
        logic [71:0] text;
        logic [71:0] shifted;
        unique case (kw)
            KW_DASH_ONE:  text = {"-1", 56'h0};
            KW_INFINITE:  text = {"INFINITE", 8'h0};
            KW_UNLIMITED: text = "UNLIMITED";
            default:      text = 72'h0;
        endcase
        shifted = 72'h0;
        if (idx < 4'(KW_MAX_LEN)) begin
            shifted = text >> {4'(KW_MAX_LEN - 1) - idx, 3'b000};
        end
        return shifted[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/dtts_parse.sv =====
// ----------------------------------------------------------------------------
// dtts_parse
// Per-character scanner: checks the form, tracks keywords, accumulates digit
// groups and, on the last character, registers a snapshot of the parse.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_parse import dtts_pkg::*; #(
    parameter int FIELD_BITS = DTTS_FIELD_BITS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dtts_in_t   s_data,
    output logic            snap_valid,
    input  wire logic       snap_ready,
    output dtts_snap_t      snap_data
);

    // Groups saturate at the largest signed value of FIELD_BITS, capped to 31 bits
    localparam int ACC_W  = (FIELD_BITS >= 32) ? 31 : FIELD_BITS - 1;
    localparam int PROD_W = ACC_W + 4;

    logic             failed_reg,    failed_next;
    logic             ended_reg,     ended_next;
    logic             in_run_reg,    in_run_next;
    logic [2:0]       groups_reg,    groups_next;
    logic [1:0]       dash_cnt_reg,  dash_cnt_next;
    logic [1:0]       colon_cnt_reg, colon_cnt_next;
    logic             lead_dash_reg, lead_dash_next;
    logic [3:0]       char_cnt_reg,  char_cnt_next;
    logic [2:0]       kw_match_reg,  kw_match_next;
    logic [ACC_W-1:0] days_reg,      days_next;
    logic [ACC_W-1:0] field_reg  [3];
    logic [ACC_W-1:0] field_next [3];
    logic [1:0]       field_idx_reg, field_idx_next;
    logic             ovf_reg,       ovf_next;

    logic             snap_valid_reg;
    dtts_snap_t       snap_reg, snap_next;

    logic             s_fire;
    logic [7:0]       c;
    logic [7:0]       up_char;
    logic [3:0]       digit;
    logic [ACC_W-1:0] cur_val;
    logic [PROD_W-1:0] prod_val;
    logic             keyword;
    logic             form_ok;
    logic             extra;
    logic             hms_form;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign s_fire     = s_valid && s_ready;
    assign snap_valid = snap_valid_reg;
    assign snap_data  = snap_reg;

    assign c       = s_data.char_code;
    assign up_char = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_GAP : c;
    assign digit   = 4'(c - CH_0);
    assign cur_val = field_reg[field_idx_reg];

    // Next-digit accumulate, times ten by shift-add
    assign prod_val = (PROD_W'(cur_val) << 3) + (PROD_W'(cur_val) << 1) + PROD_W'(digit);

    // Character scan, snapshot and clear after the last character
    always_comb begin
        failed_next    = failed_reg;
        ended_next     = ended_reg;
        in_run_next    = in_run_reg;
        groups_next    = groups_reg;
        dash_cnt_next  = dash_cnt_reg;
        colon_cnt_next = colon_cnt_reg;
        lead_dash_next = lead_dash_reg;
        char_cnt_next  = char_cnt_reg;
        kw_match_next  = kw_match_reg;
        days_next      = days_reg;
        for (int i = 0; i < 3; i++) begin
            field_next[i] = field_reg[i];
        end
        field_idx_next = field_idx_reg;
        ovf_next       = ovf_reg;

        if (!ended_reg) begin
            if (c == CH_NUL) begin
                ended_next = 1'b1;
            end else begin
                // keyword tracking, case-insensitive
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (char_cnt_reg >= kw_len(2'(k)) ||
                        kw_char(2'(k), char_cnt_reg) != up_char) begin
                        kw_match_next[k] = 1'b0;
                    end
                end

                if (c >= CH_0 && c <= CH_9) begin
                    for (int i = 0; i < 3; i++) begin
                        if (field_idx_reg == 2'(i)) begin
                            if (|prod_val[PROD_W-1:ACC_W]) begin
                                field_next[i] = '1;
                                ovf_next      = 1'b1;
                            end else begin
                                field_next[i] = prod_val[ACC_W-1:0];
                            end
                        end
                    end
                    if (!in_run_reg) begin
                        in_run_next = 1'b1;
                        if (groups_reg != 3'd7) begin
                            groups_next = groups_reg + 3'd1;
                        end
                    end
                end else if (c == CH_DASH) begin
                    in_run_next = 1'b0;
                    if (char_cnt_reg == 4'd0) begin
                        lead_dash_next = 1'b1;
                    end
                    if (colon_cnt_reg != 2'd0) begin
                        failed_next = 1'b1;
                    end
                    if (dash_cnt_reg == 2'd0) begin
                        days_next     = field_reg[0];
                        field_next[0] = '0;
                    end
                    if (dash_cnt_reg != 2'd3) begin
                        dash_cnt_next = dash_cnt_reg + 2'd1;
                    end
                end else if (c == CH_COLON) begin
                    in_run_next = 1'b0;
                    if (colon_cnt_reg != 2'd3) begin
                        colon_cnt_next = colon_cnt_reg + 2'd1;
                    end
                    if (field_idx_reg < 2'd2) begin
                        field_idx_next = field_idx_reg + 2'd1;
                    end
                end else begin
                    failed_next = 1'b1;
                end

                if (char_cnt_reg != 4'd15) begin
                    char_cnt_next = char_cnt_reg + 4'd1;
                end
            end
        end

        // full keyword seen
        keyword = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_match_next[k] && char_cnt_next == kw_len(2'(k))) begin
                keyword = 1'b1;
            end
        end

        // form check
        extra   = (dash_cnt_next != 2'd0);
        form_ok = !(failed_next || lead_dash_next || groups_next == 3'd0 ||
                    dash_cnt_next > 2'd1 || colon_cnt_next > 2'd2 ||
                    (colon_cnt_next == 2'd1 && groups_next < 3'd2 + {2'b00, extra}) ||
                    (colon_cnt_next == 2'd2 && groups_next < 3'd3 + {2'b00, extra}));

        priority if (char_cnt_next == 4'd0) begin
            snap_next.status = ST_INVALID;
        end else if (keyword) begin
            snap_next.status = ST_INFINITE;
        end else if (!form_ok) begin
            snap_next.status = ST_INVALID;
        end else if (ovf_next) begin
            snap_next.status = ST_OVERFLOW;
        end else begin
            snap_next.status = ST_OK;
        end

        // m and m:s lack an hours field
        hms_form       = extra || (colon_cnt_next == 2'd2);
        snap_next.days = SEC_W'(days_next);
        if (hms_form) begin
            snap_next.hours = SEC_W'(field_next[0]);
            snap_next.mins  = SEC_W'(field_next[1]);
            snap_next.secs  = SEC_W'(field_next[2]);
        end else begin
            snap_next.hours = '0;
            snap_next.mins  = SEC_W'(field_next[0]);
            snap_next.secs  = SEC_W'(field_next[1]);
        end

        // fresh text after each result
        if (s_data.last_char) begin
            failed_next    = 1'b0;
            ended_next     = 1'b0;
            in_run_next    = 1'b0;
            groups_next    = '0;
            dash_cnt_next  = '0;
            colon_cnt_next = '0;
            lead_dash_next = 1'b0;
            char_cnt_next  = '0;
            kw_match_next  = '1;
            days_next      = '0;
            for (int i = 0; i < 3; i++) begin
                field_next[i] = '0;
            end
            field_idx_next = '0;
            ovf_next       = 1'b0;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failed_reg    <= 1'b0;
            ended_reg     <= 1'b0;
            in_run_reg    <= 1'b0;
            groups_reg    <= '0;
            dash_cnt_reg  <= '0;
            colon_cnt_reg <= '0;
            lead_dash_reg <= 1'b0;
            char_cnt_reg  <= '0;
            kw_match_reg  <= '1;
            days_reg      <= '0;
            for (int i = 0; i < 3; i++) begin
                field_reg[i] <= '0;
            end
            field_idx_reg <= '0;
            ovf_reg       <= 1'b0;
        end else if (s_fire) begin
            failed_reg    <= failed_next;
            ended_reg     <= ended_next;
            in_run_reg    <= in_run_next;
            groups_reg    <= groups_next;
            dash_cnt_reg  <= dash_cnt_next;
            colon_cnt_reg <= colon_cnt_next;
            lead_dash_reg <= lead_dash_next;
            char_cnt_reg  <= char_cnt_next;
            kw_match_reg  <= kw_match_next;
            days_reg      <= days_next;
            for (int i = 0; i < 3; i++) begin
                field_reg[i] <= field_next[i];
            end
            field_idx_reg <= field_idx_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Snapshot valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (s_fire && s_data.last_char) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_ready) begin
            snap_valid_reg <= 1'b0;
        end
    end

    // Snapshot word
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.last_char) begin
            snap_reg <= snap_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dtts_total.sv =====
// ----------------------------------------------------------------------------
// dtts_total
// Two-stage seconds total: constant scaling of each part, then the sum with
// the range check and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_total import dtts_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       snap_valid,
    output logic            snap_ready,
    input  wire dtts_snap_t snap_data,
    output logic            secs_valid,
    input  wire logic       secs_ready,
    output dtts_secs_t      secs_data
);

    localparam int DAY_W  = SEC_W + 17;
    localparam int HOUR_W = SEC_W + 12;
    localparam int MIN_PW = SEC_W + 6;
    localparam int SUM_W  = DAY_W + 1;

    logic              a_valid_reg;
    logic              a_ready;
    status_t           a_status_reg;
    logic [DAY_W-1:0]  a_days_reg;
    logic [HOUR_W-1:0] a_hours_reg;
    logic [MIN_PW-1:0] a_mins_reg;
    logic [SEC_W-1:0]  a_secs_reg;

    logic              b_valid_reg;
    dtts_secs_t        b_reg, b_next;
    logic [SUM_W-1:0]  sum;

    assign a_ready    = !b_valid_reg || secs_ready;
    assign snap_ready = !a_valid_reg || a_ready;
    assign secs_valid = b_valid_reg;
    assign secs_data  = b_reg;

    // Sum and range check
    always_comb begin
        sum = SUM_W'(a_days_reg) + SUM_W'(a_hours_reg) + SUM_W'(a_mins_reg) +
              SUM_W'(a_secs_reg);
        b_next.status  = a_status_reg;
        b_next.seconds = '0;
        unique case (a_status_reg)
            ST_OK: begin
                if (|sum[SUM_W-1:SEC_W]) begin
                    b_next.status  = ST_OVERFLOW;
                    b_next.seconds = MAX_TOTAL;
                end else begin
                    b_next.seconds = sum[SEC_W-1:0];
                end
            end
            ST_OVERFLOW: b_next.seconds = MAX_TOTAL;
            default:     b_next.seconds = '0;
        endcase
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (snap_ready) begin
                a_valid_reg <= snap_valid;
            end
            if (a_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Scaled parts, then total
    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            a_status_reg <= snap_data.status;
            a_days_reg   <= DAY_W'(snap_data.days) * DAY_W'(SECS_PER_DAY);
            a_hours_reg  <= HOUR_W'(snap_data.hours) * HOUR_W'(SECS_PER_HOUR);
            a_mins_reg   <= MIN_PW'(snap_data.mins) * MIN_PW'(SECS_PER_MIN);
            a_secs_reg   <= snap_data.secs;
        end
        if (a_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dtts_minutes.sv =====
// ----------------------------------------------------------------------------
// dtts_minutes
// Minutes rounded up: (seconds + 59) / 60 as a quarter then a reciprocal
// multiply by 1/15, followed by the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtts_minutes import dtts_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       secs_valid,
    output logic            secs_ready,
    input  wire dtts_secs_t secs_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output dtts_out_t       m_data
);

    localparam int QTR_W  = SEC_W - 1;
    localparam int PROD_W = QTR_W + 32;

    logic              c_valid_reg;
    logic              c_ready;
    dtts_secs_t        c_secs_reg;
    logic [PROD_W-1:0] c_prod_reg;

    logic              m_valid_reg;
    dtts_out_t         m_data_reg;

    logic [SEC_W:0]    rounded;
    logic [QTR_W-1:0]  quarter;
    logic [PROD_W-1:0] shifted;

    assign c_ready    = !m_valid_reg || m_ready;
    assign secs_ready = !c_valid_reg || c_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Round up, then divide by four
    assign rounded = (SEC_W + 1)'(secs_data.seconds) + (SEC_W + 1)'(ROUND_UP_MIN);
    assign quarter = rounded[SEC_W:2];
    assign shifted = c_prod_reg >> RECIP_SHIFT;

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (secs_ready) begin
                c_valid_reg <= secs_valid;
            end
            if (c_ready) begin
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // Reciprocal product, then result word
    always_ff @(posedge aclk) begin
        if (secs_ready && secs_valid) begin
            c_secs_reg <= secs_data;
            c_prod_reg <= PROD_W'(quarter) * PROD_W'(RECIP_15);
        end
        if (c_ready && c_valid_reg) begin
            m_data_reg.status        <= c_secs_reg.status;
            m_data_reg.total_seconds <= c_secs_reg.seconds;
            m_data_reg.total_minutes <= shifted[MIN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/duration_text_to_seconds_core.sv =====
// ----------------------------------------------------------------------------
// duration_text_to_seconds_core
// Duration text to seconds: one character per word in, one result word out
// per text, with status ok, infinite, invalid or overflow.
//
// Throughput: one character per cycle while no downstream stage applies back-pressure,
//   including back-to-back texts. The last character taken is registered as a snapshot,
//   then passes through scaling, sum, reciprocal product and the result register.
// Reset: synchronous, active low; clears the scan state and all stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module duration_text_to_seconds_core import dtts_pkg::*; #(
    parameter int FIELD_BITS = DTTS_FIELD_BITS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dtts_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output dtts_out_t       m_data
);

    logic       snap_valid;
    logic       snap_ready;
    dtts_snap_t snap_data;
    logic       secs_valid;
    logic       secs_ready;
    dtts_secs_t secs_data;

    // Character scan
    dtts_parse #(
        .FIELD_BITS (FIELD_BITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data)
    );

    // Seconds total
    dtts_total u_total (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data),
        .secs_valid (secs_valid),
        .secs_ready (secs_ready),
        .secs_data  (secs_data)
    );

    // Minutes and result register
    dtts_minutes u_minutes (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .secs_valid (secs_valid),
        .secs_ready (secs_ready),
        .secs_data  (secs_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
